// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the playfair cipher RTL.
// No dependencies; simulation builds get checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define PFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pfc assertion failed");

// Condition in one cycle implies a consequence in the next.
`define PFC_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("pfc assertion failed");

`else

`define PFC_ASSERT(lbl, clk, rst_n, prop)
`define PFC_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)

`endif

`endif

// ===== rtl/pfc_pkg.sv =====
// Package for the playfair cipher core: field widths, letter codes, actions,
// the symbol decode function and the structs passed to the pair transform.
`default_nettype none

package pfc_pkg;

    localparam int ACTION_W    = 2;
    localparam int SYMBOL_W    = 8;
    localparam int ASCII_W     = 7;
    localparam int LETTER_W    = 5;
    localparam int NUM_LETTERS = 26;
    localparam int NUM_CELLS   = 25;

    typedef logic [LETTER_W-1:0] letter_t;

    localparam letter_t LETTER_I   = 5'd8;
    localparam letter_t LETTER_J   = 5'd9;
    localparam letter_t LETTER_X   = 5'd23;
    localparam letter_t LETTER_Z   = 5'd25;
    localparam letter_t NO_LETTER  = 5'd31;
    localparam letter_t CELLS_FULL = 5'd25;

    localparam logic [ASCII_W-1:0]  ASCII_UPPER_A = 7'd65;
    localparam logic [SYMBOL_W-1:0] SYM_UPPER_A   = 8'd65;
    localparam logic [SYMBOL_W-1:0] SYM_UPPER_Z   = 8'd90;
    localparam logic [SYMBOL_W-1:0] SYM_LOWER_A   = 8'd97;
    localparam logic [SYMBOL_W-1:0] SYM_LOWER_Z   = 8'd122;

    typedef enum logic [ACTION_W-1:0] {
        ACT_KEY_BYTE  = 2'd0,
        ACT_KEY_END   = 2'd1,
        ACT_TEXT_BYTE = 2'd2,
        ACT_TEXT_END  = 2'd3
    } action_t;

    typedef struct packed {
        logic    ok;
        letter_t idx;
    } sym_decode_t;

    // Two cells of a pair and the shift direction
    typedef struct packed {
        letter_t ca;
        letter_t cb;
        logic    dec;
    } xform_req_t;

    // Cells holding the two transformed letters
    typedef struct packed {
        letter_t oa;
        letter_t ob;
    } xform_rsp_t;

    // Case-folded letter index of an ASCII byte, ok low for non-letters
    function automatic sym_decode_t letter_of(input logic [SYMBOL_W-1:0] sym);
        sym_decode_t d;
        d.ok  = 1'b0;
        d.idx = '0;
        if (sym >= SYM_LOWER_A && sym <= SYM_LOWER_Z) begin
            d.ok  = 1'b1;
            d.idx = letter_t'(sym - SYM_LOWER_A);
        end else if (sym >= SYM_UPPER_A && sym <= SYM_UPPER_Z) begin
            d.ok  = 1'b1;
            d.idx = letter_t'(sym - SYM_UPPER_A);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pfc_in_if.sv =====
// Input channel of the playfair cipher core: action and raw symbol byte.
// Depends on pfc_pkg for the field widths.
`default_nettype none

interface pfc_in_if;
    logic                          valid;
    logic                          ready;
    logic [pfc_pkg::ACTION_W-1:0]  action;
    logic [pfc_pkg::SYMBOL_W-1:0]  symbol;

    modport source (output valid, output action, output symbol, input ready);
    modport sink   (input valid, input action, input symbol, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfc_out_if.sv =====
// Output channel of the playfair cipher core: one ASCII letter per transaction.
// Depends on pfc_pkg for the field widths.
`default_nettype none

interface pfc_out_if;
    logic                         valid;
    logic                         ready;
    logic [pfc_pkg::ASCII_W-1:0]  letter;
    logic                         last_of_run;

    modport source (output valid, output letter, output last_of_run, input ready);
    modport sink   (input valid, input letter, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/playfair_digraph_cipher_core.sv =====
// Playfair cipher core: key grid build, text pairing and pair transform.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if, pfc_ram, pfc_pair_xform and
// assert_macros.svh.
//
// Use: items come in on req (action, symbol); letters leave on rsp, one per
// transaction, with last_of_run marking the final letter of an item. The
// direction register (0 encrypt, 1 decrypt) is written through cfg_we and
// cfg_wdata; the user must write it only while the core is idle, which the
// core itself does not enforce.
// Timing: req is taken one item at a time. A key byte, a text letter that
// only waits for its partner, and any skipped byte are done without leaving
// idle. Key end walks the alphabet through the grid write port. An item that
// forms a pair reads two cells, then two grid letters, one after the other
// on the single read port of each RAM, then emits its two letters in turn.
// A doubled X emits two identical pairs.
// Reset clears the key state, the text state and direction; the grid RAMs
// are not cleared, text is ignored until a key end has filled them.
// A stalled rsp holds its letter; the core waits with the next letter in
// its own registers and accepts no new item until its last letter is loaded.
`default_nettype none
`include "assert_macros.svh"

module playfair_digraph_cipher_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pfc_in_if.sink     req,
    pfc_out_if.source  rsp,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata
);
    import pfc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_CELL_A,
        S_CELL_B,
        S_GRID_A,
        S_GRID_B,
        S_LET_B,
        S_EMIT_A,
        S_EMIT_B
    } state_t;

    state_t                 state_reg, state_next;
    logic                   direction_reg, direction_next;
    logic [NUM_LETTERS-1:0] used_reg, used_next;
    letter_t                fill_count_reg, fill_count_next;
    logic                   key_closed_reg, key_closed_next;
    letter_t                pending_letter_reg, pending_letter_next;
    logic                   pending_valid_reg, pending_valid_next;
    letter_t                prev_second_reg, prev_second_next;
    letter_t                walk_reg, walk_next;
    letter_t                pair_a_reg, pair_a_next;
    letter_t                pair_b_reg, pair_b_next;
    logic                   pair_dec_reg, pair_dec_next;
    logic [1:0]             pair_cnt_reg, pair_cnt_next;
    letter_t                ca_reg, ca_next;
    letter_t                ob_reg, ob_next;
    letter_t                let_a_reg, let_a_next;
    letter_t                let_b_reg, let_b_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ASCII_W-1:0]     out_letter_reg, out_letter_next;
    logic                   out_last_reg, out_last_next;

    // RAM ports
    logic    grid_we, cell_we;
    letter_t grid_waddr, grid_wdata, grid_raddr, grid_rdata;
    letter_t cell_waddr, cell_wdata, cell_raddr, cell_rdata;

    xform_req_t xreq;
    xform_rsp_t xrsp;

    sym_decode_t            sym_dec;
    letter_t                text_l;
    logic [NUM_LETTERS-1:0] base_used;
    letter_t                base_fill;
    logic                   slot_free;
    logic                   out_push;

    // Grid: cell -> letter
    pfc_ram #(.WIDTH(LETTER_W), .DEPTH(NUM_CELLS)) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    // Inverse map: letter -> cell
    pfc_ram #(.WIDTH(LETTER_W), .DEPTH(NUM_LETTERS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    assign xreq.ca  = ca_reg;
    assign xreq.cb  = cell_rdata;
    assign xreq.dec = pair_dec_reg;

    pfc_pair_xform u_xform (
        .req (xreq),
        .rsp (xrsp)
    );

    // Symbol decode, J folds to I for text
    assign sym_dec   = letter_of(req.symbol);
    assign text_l    = (sym_dec.idx == LETTER_J) ? LETTER_I : sym_dec.idx;
    assign base_used = key_closed_reg ? '0 : used_reg;
    assign base_fill = key_closed_reg ? '0 : fill_count_reg;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.letter      = out_letter_reg;
    assign rsp.last_of_run = out_last_reg;
    assign slot_free       = !out_valid_reg || rsp.ready;

    // Next-state logic
    always_comb
    begin
        state_next          = state_reg;
        direction_next      = cfg_we ? cfg_wdata : direction_reg;
        used_next           = used_reg;
        fill_count_next     = fill_count_reg;
        key_closed_next     = key_closed_reg;
        pending_letter_next = pending_letter_reg;
        pending_valid_next  = pending_valid_reg;
        prev_second_next    = prev_second_reg;
        walk_next           = walk_reg;
        pair_a_next         = pair_a_reg;
        pair_b_next         = pair_b_reg;
        pair_dec_next       = pair_dec_reg;
        pair_cnt_next       = pair_cnt_reg;
        ca_next             = ca_reg;
        ob_next             = ob_reg;
        let_a_next          = let_a_reg;
        let_b_next          = let_b_reg;
        out_push            = 1'b0;
        out_letter_next     = out_letter_reg;
        out_last_next       = out_last_reg;
        grid_we             = 1'b0;
        grid_waddr          = fill_count_reg;
        grid_wdata          = walk_reg;
        cell_we             = 1'b0;
        cell_waddr          = walk_reg;
        cell_wdata          = fill_count_reg;
        grid_raddr          = ob_reg;
        cell_raddr          = pair_a_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.action)
                        ACT_KEY_BYTE:
                        begin
                            // New key after a closed one starts from an empty grid
                            if (key_closed_reg)
                            begin
                                key_closed_next     = 1'b0;
                                pending_letter_next = '0;
                                pending_valid_next  = 1'b0;
                                prev_second_next    = NO_LETTER;
                            end
                            used_next       = base_used;
                            fill_count_next = base_fill;
                            if (sym_dec.ok && sym_dec.idx != LETTER_J &&
                                base_fill < CELLS_FULL && !base_used[sym_dec.idx])
                            begin
                                grid_we         = 1'b1;
                                grid_waddr      = base_fill;
                                grid_wdata      = sym_dec.idx;
                                cell_we         = 1'b1;
                                cell_waddr      = sym_dec.idx;
                                cell_wdata      = base_fill;
                                used_next       = base_used |
                                                  (NUM_LETTERS'(1) << sym_dec.idx);
                                fill_count_next = base_fill + 5'd1;
                            end
                        end
                        ACT_KEY_END:
                        begin
                            key_closed_next     = 1'b1;
                            pending_letter_next = '0;
                            pending_valid_next  = 1'b0;
                            prev_second_next    = NO_LETTER;
                            walk_next           = '0;
                            state_next          = S_FILL;
                        end
                        ACT_TEXT_BYTE:
                        begin
                            if (key_closed_reg && sym_dec.ok)
                            begin
                                pair_dec_next = direction_reg;
                                pair_cnt_next = 2'd1;
                                if (direction_reg)
                                begin
                                    // Decrypt pairs letters as they come
                                    if (pending_valid_reg)
                                    begin
                                        pair_a_next        = pending_letter_reg;
                                        pair_b_next        = text_l;
                                        pending_valid_next = 1'b0;
                                        state_next         = S_CELL_A;
                                    end
                                    else
                                    begin
                                        pending_letter_next = text_l;
                                        pending_valid_next  = 1'b1;
                                    end
                                end
                                else if (!pending_valid_reg)
                                begin
                                    // Letter repeating the last second letter gets X
                                    if (prev_second_reg == text_l)
                                    begin
                                        pair_a_next = LETTER_X;
                                        pair_b_next = text_l;
                                        state_next  = S_CELL_A;
                                    end
                                    else
                                    begin
                                        pending_letter_next = text_l;
                                        pending_valid_next  = 1'b1;
                                    end
                                end
                                else if (pending_letter_reg == text_l)
                                begin
                                    // Doubled letter: (l, X), then l starts again.
                                    // Only a doubled X yields a second pair, (X, X).
                                    pair_a_next      = text_l;
                                    pair_b_next      = LETTER_X;
                                    prev_second_next = LETTER_X;
                                    state_next       = S_CELL_A;
                                    if (text_l == LETTER_X)
                                    begin
                                        pair_cnt_next      = 2'd2;
                                        pending_valid_next = 1'b0;
                                    end
                                    else
                                    begin
                                        pending_letter_next = text_l;
                                        pending_valid_next  = 1'b1;
                                    end
                                end
                                else
                                begin
                                    pair_a_next        = pending_letter_reg;
                                    pair_b_next        = text_l;
                                    prev_second_next   = text_l;
                                    pending_valid_next = 1'b0;
                                    state_next         = S_CELL_A;
                                end
                            end
                        end
                        ACT_TEXT_END:
                        begin
                            if (key_closed_reg)
                            begin
                                // Lone letter at the end is padded with X when encrypting
                                if (pending_valid_reg && !direction_reg)
                                begin
                                    pair_a_next   = pending_letter_reg;
                                    pair_b_next   = LETTER_X;
                                    pair_dec_next = 1'b0;
                                    pair_cnt_next = 2'd1;
                                    state_next    = S_CELL_A;
                                end
                                pending_letter_next = '0;
                                pending_valid_next  = 1'b0;
                                prev_second_next    = NO_LETTER;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                // Place unused letters, J left out
                if (walk_reg != LETTER_J && fill_count_reg < CELLS_FULL &&
                    !used_reg[walk_reg])
                begin
                    grid_we         = 1'b1;
                    cell_we         = 1'b1;
                    used_next       = used_reg | (NUM_LETTERS'(1) << walk_reg);
                    fill_count_next = fill_count_reg + 5'd1;
                end
                walk_next = walk_reg + 5'd1;
                if (walk_reg == LETTER_Z)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CELL_A:
            begin
                cell_raddr = pair_a_reg;
                state_next = S_CELL_B;
            end
            S_CELL_B:
            begin
                cell_raddr = pair_b_reg;
                ca_next    = cell_rdata;
                state_next = S_GRID_A;
            end
            S_GRID_A:
            begin
                grid_raddr = xrsp.oa;
                ob_next    = xrsp.ob;
                state_next = S_GRID_B;
            end
            S_GRID_B:
            begin
                grid_raddr = ob_reg;
                let_a_next = grid_rdata;
                state_next = S_LET_B;
            end
            S_LET_B:
            begin
                let_b_next = grid_rdata;
                state_next = S_EMIT_A;
            end
            S_EMIT_A:
            begin
                if (slot_free)
                begin
                    out_push        = 1'b1;
                    out_letter_next = ASCII_UPPER_A + ASCII_W'(let_a_reg);
                    out_last_next   = 1'b0;
                    state_next      = S_EMIT_B;
                end
            end
            S_EMIT_B:
            begin
                if (slot_free)
                begin
                    out_push        = 1'b1;
                    out_letter_next = ASCII_UPPER_A + ASCII_W'(let_b_reg);
                    out_last_next   = (pair_cnt_reg == 2'd1);
                    pair_cnt_next   = pair_cnt_reg - 2'd1;
                    state_next      = (pair_cnt_reg == 2'd1) ? S_IDLE : S_EMIT_A;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output register: load on push, drop when taken
        if (out_push)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            direction_reg      <= 1'b0;
            used_reg           <= '0;
            fill_count_reg     <= '0;
            key_closed_reg     <= 1'b0;
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
            prev_second_reg    <= NO_LETTER;
            walk_reg           <= '0;
            pair_cnt_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            direction_reg      <= direction_next;
            used_reg           <= used_next;
            fill_count_reg     <= fill_count_next;
            key_closed_reg     <= key_closed_next;
            pending_letter_reg <= pending_letter_next;
            pending_valid_reg  <= pending_valid_next;
            prev_second_reg    <= prev_second_next;
            walk_reg           <= walk_next;
            pair_cnt_reg       <= pair_cnt_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pair_a_reg     <= pair_a_next;
        pair_b_reg     <= pair_b_next;
        pair_dec_reg   <= pair_dec_next;
        ca_reg         <= ca_next;
        ob_reg         <= ob_next;
        let_a_reg      <= let_a_next;
        let_b_reg      <= let_b_next;
        out_letter_reg <= out_letter_next;
        out_last_reg   <= out_last_next;
    end

    // Checks
    `PFC_ASSERT(a_fill_bound, clk, rst_n, fill_count_reg <= CELLS_FULL)
    `PFC_ASSERT(a_grid_full, clk, rst_n,
        (key_closed_reg && state_reg == S_IDLE) |-> (fill_count_reg == CELLS_FULL))
    `PFC_ASSERT(a_push_slot, clk, rst_n, out_push |-> (!out_valid_reg || rsp.ready))
    `PFC_ASSERT(a_cell_range, clk, rst_n, (state_reg == S_GRID_A) |-> (ca_reg < CELLS_FULL))
    `PFC_ASSERT_NEXT(a_pair_count, clk, rst_n, state_reg == S_IDLE && state_next == S_CELL_A,
        pair_cnt_reg == 2'd1 || pair_cnt_reg == 2'd2)

endmodule

`default_nettype wire

// ===== rtl/pfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/pfc_pair_xform.sv =====
// Playfair pair rule on grid cells: same column, same row or rectangle.
// Depends on pfc_pkg for the request and response structs.
`default_nettype none

module pfc_pair_xform (
    input  wire pfc_pkg::xform_req_t req,
    output pfc_pkg::xform_rsp_t      rsp
);
    import pfc_pkg::*;

    // Row of a cell by compare chain
    function automatic logic [2:0] row_of(input letter_t c);
        logic [2:0] r;
        if (c >= 5'd20)      r = 3'd4;
        else if (c >= 5'd15) r = 3'd3;
        else if (c >= 5'd10) r = 3'd2;
        else if (c >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    // Row times five
    function automatic letter_t times5(input logic [2:0] r);
        return {r, 2'b00} + {2'b00, r};
    endfunction

    // One step along a row or column, wrapping mod 5
    function automatic logic [2:0] step(input logic [2:0] v, input logic dec);
        logic [2:0] s;
        if (dec) s = (v == 3'd0) ? 3'd4 : v - 3'd1;
        else     s = (v == 3'd4) ? 3'd0 : v + 3'd1;
        return s;
    endfunction

    logic [2:0] ra, rb, ka, kb;
    logic [2:0] ra_o, rb_o, ka_o, kb_o;

    assign ra = row_of(req.ca);
    assign rb = row_of(req.cb);
    assign ka = 3'(req.ca - times5(ra));
    assign kb = 3'(req.cb - times5(rb));

    // Pick the rule
    always_comb
    begin
        ra_o = ra;
        rb_o = rb;
        ka_o = kb;
        kb_o = ka;
        if (ka == kb)
        begin
            ra_o = step(ra, req.dec);
            rb_o = step(rb, req.dec);
            ka_o = ka;
            kb_o = kb;
        end
        else if (ra == rb)
        begin
            ka_o = step(ka, req.dec);
            kb_o = step(kb, req.dec);
        end
    end

    assign rsp.oa = times5(ra_o) + {2'b00, ka_o};
    assign rsp.ob = times5(rb_o) + {2'b00, kb_o};

endmodule

`default_nettype wire
